### rtl/core/mexp_pkg.sv
// Shared constants and types for the modular exponentiation core.
`default_nettype none

package mexp_pkg;

    // Operand width of base, exponent, modulus and result.
    localparam int WIDTH = 32;

    // Width of the bit counter of the shared modular multiplier.
    localparam int CNT_W = (WIDTH > 2) ? $clog2(WIDTH) : 1;

    // Sequencer states, one-hot coded.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_MULT   = 5'b00100,
        ST_SQUARE = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    typedef logic [WIDTH-1:0] word_t;

endpackage

`default_nettype wire

### rtl/core/modular_exponentiation_core.sv
// Top level of the modular exponentiation core: sequencer and shared modular multiplier.
//
// Computes base_value ** exponent_value mod modulus_value with right-to-left binary
// square-and-multiply on WIDTH-bit unsigned operands. All work runs through one shared
// shift-and-add modular multiplier that handles one multiplier bit per cycle. A transaction
// first reduces the base with one modular multiplication, then does one multiplication
// for every set exponent bit and one squaring for every exponent bit below the highest
// set bit; the squaring after the highest set bit is skipped. After the last multiplication
// the sequencer enters ST_FINISH, which loads the result into the output register and
// returns to ST_IDLE, where the core accepts again. A zero modulus goes straight to
// ST_FINISH and gives zero_modulus_error set and a zero result; a zero exponent returns 1.
// in_ready is high only while the core is idle. The result sits in an output register,
// so a new transaction may be accepted while the previous result still waits; a finished
// transaction is held back only while that register is still occupied.
`default_nettype none

module modular_exponentiation_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [mexp_pkg::WIDTH-1:0] base_value,
    input  wire logic [mexp_pkg::WIDTH-1:0] exponent_value,
    input  wire logic [mexp_pkg::WIDTH-1:0] modulus_value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [mexp_pkg::WIDTH-1:0]      power_result,
    output logic                            zero_modulus_error
);

    localparam int W = mexp_pkg::WIDTH;
    localparam int CW = mexp_pkg::CNT_W;

    mexp_pkg::state_t state_reg, state_next;

    // Operand and intermediate registers.
    mexp_pkg::word_t mod_reg, mod_next;
    mexp_pkg::word_t exp_reg, exp_next;
    mexp_pkg::word_t acc_reg, acc_next;
    mexp_pkg::word_t sq_reg, sq_next;
    logic            err_reg, err_next;

    // Shared multiplier registers: addend, scanned multiplier, partial product, bit count.
    mexp_pkg::word_t mx_reg, mx_next;
    mexp_pkg::word_t my_reg, my_next;
    mexp_pkg::word_t prod_reg, prod_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    // Output register.
    logic            out_valid_reg, out_valid_next;
    mexp_pkg::word_t res_reg, res_next;
    logic            res_err_reg, res_err_next;

    // Shared multiplier datapath: prod = (2 * prod + (bit ? x : 0)) mod m.
    logic [W:0]      dbl;
    mexp_pkg::word_t dbl_red;
    mexp_pkg::word_t addend;
    logic [W:0]      sum;
    logic [W:0]      sum_sub;
    mexp_pkg::word_t step_val;
    logic            op_last;

    always_comb
    begin
        dbl      = {prod_reg, 1'b0};
        dbl_red  = (dbl >= {1'b0, mod_reg}) ? W'(dbl - {1'b0, mod_reg}) : dbl[W-1:0];
        addend   = my_reg[W-1] ? mx_reg : '0;
        sum      = {1'b0, dbl_red} + {1'b0, addend};
        sum_sub  = sum - {1'b0, mod_reg};
        step_val = (sum >= {1'b0, mod_reg}) ? sum_sub[W-1:0] : sum[W-1:0];
        op_last  = (cnt_reg == '0);
    end

    // Sequencer and register next-value logic.
    always_comb
    begin
        state_next     = state_reg;
        mod_next       = mod_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        err_next       = err_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        res_err_next   = res_err_reg;

        // The consumer takes the waiting result.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Any running multiplication advances by one multiplier bit.
        if ((state_reg == mexp_pkg::ST_REDUCE) || (state_reg == mexp_pkg::ST_MULT) ||
            (state_reg == mexp_pkg::ST_SQUARE))
        begin
            prod_next = step_val;
            my_next   = my_reg << 1;
            cnt_next  = cnt_reg - 1'b1;
        end

        case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    mod_next  = modulus_value;
                    exp_next  = exponent_value;
                    acc_next  = mexp_pkg::word_t'(1);
                    prod_next = '0;
                    cnt_next  = CW'(W - 1);
                    // Reduce the base as 1 * base mod m.
                    mx_next   = mexp_pkg::word_t'(1);
                    my_next   = base_value;
                    if (modulus_value == '0)
                    begin
                        acc_next   = '0;
                        err_next   = 1'b1;
                        state_next = mexp_pkg::ST_FINISH;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        state_next = mexp_pkg::ST_REDUCE;
                    end
                end
            end

            mexp_pkg::ST_REDUCE:
            begin
                if (op_last)
                begin
                    sq_next   = step_val;
                    prod_next = '0;
                    cnt_next  = CW'(W - 1);
                    my_next   = step_val;
                    if (exp_reg == '0)
                    begin
                        state_next = mexp_pkg::ST_FINISH;
                    end
                    else if (exp_reg[0])
                    begin
                        mx_next    = acc_reg;
                        state_next = mexp_pkg::ST_MULT;
                    end
                    else
                    begin
                        mx_next    = step_val;
                        state_next = mexp_pkg::ST_SQUARE;
                    end
                end
            end

            mexp_pkg::ST_MULT:
            begin
                if (op_last)
                begin
                    acc_next  = step_val;
                    prod_next = '0;
                    cnt_next  = CW'(W - 1);
                    mx_next   = sq_reg;
                    my_next   = sq_reg;
                    // No higher set bit remains, so the last squaring is not needed.
                    if (exp_reg[W-1:1] == '0)
                    begin
                        state_next = mexp_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = mexp_pkg::ST_SQUARE;
                    end
                end
            end

            mexp_pkg::ST_SQUARE:
            begin
                if (op_last)
                begin
                    sq_next   = step_val;
                    exp_next  = exp_reg >> 1;
                    prod_next = '0;
                    cnt_next  = CW'(W - 1);
                    my_next   = step_val;
                    // The shifted exponent is never zero here.
                    if (exp_reg[1])
                    begin
                        mx_next    = acc_reg;
                        state_next = mexp_pkg::ST_MULT;
                    end
                    else
                    begin
                        mx_next    = step_val;
                        state_next = mexp_pkg::ST_SQUARE;
                    end
                end
            end

            mexp_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    res_next       = acc_reg;
                    res_err_next   = err_reg;
                    state_next     = mexp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mod_reg     <= mod_next;
        exp_reg     <= exp_next;
        acc_reg     <= acc_next;
        sq_reg      <= sq_next;
        err_reg     <= err_next;
        mx_reg      <= mx_next;
        my_reg      <= my_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
        res_err_reg <= res_err_next;
    end

    assign in_ready           = (state_reg == mexp_pkg::ST_IDLE);
    assign out_valid          = out_valid_reg;
    assign power_result       = res_reg;
    assign zero_modulus_error = res_err_reg;

endmodule

`default_nettype wire

### rtl/core/mexp_checker.sv
// Port-level checker for the modular exponentiation core, bound to the top level.
`default_nettype none

module mexp_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic [mexp_pkg::WIDTH-1:0] base_value,
    input wire logic [mexp_pkg::WIDTH-1:0] exponent_value,
    input wire logic [mexp_pkg::WIDTH-1:0] modulus_value,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [mexp_pkg::WIDTH-1:0] power_result,
    input wire logic                       zero_modulus_error
);

    // A flagged zero modulus always comes with a zero result.
    a_err_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_modulus_error) |-> (power_result == '0))
        else $error("zero modulus transaction returned a nonzero result");

    // After accepting a transaction the core is busy in the cycle after.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("core ready again right after accepting a transaction");

    // A stalled result holds its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(power_result) && $stable(zero_modulus_error)))
        else $error("stalled result changed or was dropped");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (.*);

`default_nettype wire
